>>> sv/m4rm_pkg.sv
// Shared types and constants for the 4x4 row-by-matrix multiplier.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package m4rm_pkg;

    localparam int ELEM_W    = 32;
    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;

    // A shifted product keeps the bits above the fraction of a full 64-bit product.
    localparam int PROD_W = 2 * ELEM_W - FRAC_BITS;
    // Four products added exactly need two more bits.
    localparam int SUM_W  = PROD_W + 2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MUL  = 1'b1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef elem_t [DIM-1:0]          row_t;
    typedef row_t [DIM-1:0]           mat_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef sum_t [DIM-1:0]           sum_row_t;

    localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } lane_ctrl_t;

endpackage

`default_nettype wire

>>> sv/m4rm_store.sv
// Right-hand matrix store: sixteen registers, written one row at a time.
// Depends on m4rm_pkg. Each column is presented to its own lane.
`default_nettype none

module m4rm_store (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire logic [1:0]     wr_row,
    input  wire m4rm_pkg::row_t wr_data,
    output m4rm_pkg::mat_t      cols
);

    m4rm_pkg::mat_t store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
        end
        else if (wr_en)
        begin
            store_reg[wr_row] <= wr_data;
        end
    end

    // Rows are stored as written; a lane needs column j, i.e. element j of every row.
    always_comb
    begin
        for (int j = 0; j < m4rm_pkg::DIM; j++)
        begin
            for (int k = 0; k < m4rm_pkg::DIM; k++)
            begin
                cols[j][k] = store_reg[k][j];
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/m4rm_lane.sv
// One column lane: four multipliers, then an exact sum of the shifted products.
// Depends on m4rm_pkg. Two register stages, each advanced by its own enable.
`default_nettype none

module m4rm_lane (
    input  wire logic                 clk,
    input  wire m4rm_pkg::lane_ctrl_t ctrl,
    input  wire m4rm_pkg::row_t       a_row,
    input  wire m4rm_pkg::row_t       b_col,
    output m4rm_pkg::sum_t            sum
);

    logic signed [2*m4rm_pkg::ELEM_W-1:0] full [m4rm_pkg::DIM];
    m4rm_pkg::prod_t prod_reg [m4rm_pkg::DIM];
    m4rm_pkg::prod_t prod_next [m4rm_pkg::DIM];
    m4rm_pkg::sum_t  sum_reg;
    m4rm_pkg::sum_t  sum_next;

    // Dropping the fraction bits is an arithmetic shift, rounding toward minus infinity.
    always_comb
    begin
        for (int k = 0; k < m4rm_pkg::DIM; k++)
        begin
            full[k]      = $signed(a_row[k]) * $signed(b_col[k]);
            prod_next[k] = full[k][2*m4rm_pkg::ELEM_W-1:m4rm_pkg::FRAC_BITS];
        end
    end

    always_comb
    begin
        sum_next = m4rm_pkg::sum_t'(prod_reg[0]) + m4rm_pkg::sum_t'(prod_reg[1])
                 + m4rm_pkg::sum_t'(prod_reg[2]) + m4rm_pkg::sum_t'(prod_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            for (int k = 0; k < m4rm_pkg::DIM; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

>>> sv/m4rm_merge.sv
// Merge stage: clips each lane's sum to 32 bits and ORs the clip flags.
// Depends on m4rm_pkg. Holds the output register of the block.
`default_nettype none

module m4rm_merge (
    input  wire logic               clk,
    input  wire logic               load,
    input  wire m4rm_pkg::sum_row_t sums,
    output m4rm_pkg::row_t          result,
    output logic                    clipped
);

    m4rm_pkg::row_t result_reg;
    m4rm_pkg::row_t result_next;
    logic           clipped_reg;
    logic           clipped_next;
    logic [m4rm_pkg::DIM-1:0] over;

    // A sum fits when all bits from the result's sign bit upward agree.
    always_comb
    begin
        for (int j = 0; j < m4rm_pkg::DIM; j++)
        begin
            over[j] = !((&sums[j][m4rm_pkg::SUM_W-1:m4rm_pkg::ELEM_W-1])
                     || !(|sums[j][m4rm_pkg::SUM_W-1:m4rm_pkg::ELEM_W-1]));
            if (!over[j])
            begin
                result_next[j] = sums[j][m4rm_pkg::ELEM_W-1:0];
            end
            else if (sums[j][m4rm_pkg::SUM_W-1])
            begin
                result_next[j] = m4rm_pkg::ELEM_MIN;
            end
            else
            begin
                result_next[j] = m4rm_pkg::ELEM_MAX;
            end
        end
        clipped_next = |over;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg  <= result_next;
            clipped_reg <= clipped_next;
        end
    end

    assign result  = result_reg;
    assign clipped = clipped_reg;

endmodule

`default_nettype wire

>>> sv/matrix4x4_row_multiply_top.sv
// Top level of the 4x4 row-by-matrix multiplier, signed Q16.16.
// Depends on m4rm_pkg, m4rm_store, m4rm_lane and m4rm_merge.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per row. With func = 0 the
//   four elements are written into row row_index of the stored right matrix and no
//   result follows. With func = 1 the elements form a row of the left matrix and one
//   result word (prod_0..prod_3, saturated) follows on the output channel
//   (out_valid / out_stall), in the order the rows were taken.
//   A multiply word passes the operand register, the product and sum registers
//   of the lanes and the output register. Throughput: one word per cycle unless
//   out_stall holds the output; the sixteen multipliers work in four column lanes
//   side by side, so nothing is shared between rows. A load takes effect at the edge
//   it is taken; a multiply taken in the very next cycle already sees the new row.
//   Reset clears the stored matrix to zero and empties the pipeline.
//   When out_stall is high the result holds steady; earlier stages keep filling
//   bubbles, and in_stall rises only once every stage holds a word.
`default_nettype none

module matrix4x4_row_multiply_top (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  func,
    input  wire logic [1:0]            row_index,
    input  wire m4rm_pkg::elem_t       elem_0,
    input  wire m4rm_pkg::elem_t       elem_1,
    input  wire m4rm_pkg::elem_t       elem_2,
    input  wire m4rm_pkg::elem_t       elem_3,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output m4rm_pkg::elem_t            prod_0,
    output m4rm_pkg::elem_t            prod_1,
    output m4rm_pkg::elem_t            prod_2,
    output m4rm_pkg::elem_t            prod_3,
    output logic                       saturated
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_take, mul_take, load_take;

    m4rm_pkg::row_t       in_row;
    m4rm_pkg::row_t       a_reg;
    m4rm_pkg::mat_t       cols;
    m4rm_pkg::sum_row_t   sums;
    m4rm_pkg::row_t       result;
    m4rm_pkg::lane_ctrl_t lane_ctrl;

    assign in_row = {elem_3, elem_2, elem_1, elem_0};

    // Each stage moves on when the one after it is empty or moving.
    assign rdy4 = !v4_reg || !out_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_stall  = !rdy1;
    assign in_take   = in_valid && rdy1;
    assign mul_take  = in_take && (func == m4rm_pkg::FUNC_MUL);
    assign load_take = in_take && (func == m4rm_pkg::FUNC_LOAD);

    assign lane_ctrl.prod_en = rdy2 && v1_reg;
    assign lane_ctrl.sum_en  = rdy3 && v2_reg;

    always_comb
    begin
        v1_next = rdy1 ? mul_take : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
        v4_next = rdy4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_take)
        begin
            a_reg <= in_row;
        end
    end

    m4rm_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_take),
        .wr_row  (row_index),
        .wr_data (in_row),
        .cols    (cols)
    );

    for (genvar j = 0; j < m4rm_pkg::DIM; j++)
    begin : g_lane
        m4rm_lane u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .a_row (a_reg),
            .b_col (cols[j]),
            .sum   (sums[j])
        );
    end

    m4rm_merge u_merge (
        .clk     (clk),
        .load    (rdy4 && v3_reg),
        .sums    (sums),
        .result  (result),
        .clipped (saturated)
    );

    assign out_valid = v4_reg;
    assign prod_0    = result[0];
    assign prod_1    = result[1];
    assign prod_2    = result[2];
    assign prod_3    = result[3];

`ifndef SYNTH
    // The input is held off only when every stage holds a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with a bubble in the pipeline");

    // A load word never enters the multiply pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && func == m4rm_pkg::FUNC_LOAD) |=> !v1_reg)
        else $error("load word entered the pipeline");

    // A clipped result shows at least one column at a range limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
        (prod_0 == m4rm_pkg::ELEM_MAX || prod_0 == m4rm_pkg::ELEM_MIN ||
         prod_1 == m4rm_pkg::ELEM_MAX || prod_1 == m4rm_pkg::ELEM_MIN ||
         prod_2 == m4rm_pkg::ELEM_MAX || prod_2 == m4rm_pkg::ELEM_MIN ||
         prod_3 == m4rm_pkg::ELEM_MAX || prod_3 == m4rm_pkg::ELEM_MIN))
        else $error("saturation flag without a clipped column");

    // A stalled multiply word in the first stage keeps its operands.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !rdy2) |=> $stable(a_reg))
        else $error("operand register changed while held");
`endif

endmodule

`default_nettype wire

>>> verif/m4rm_checker.sv
// Result checker for the 4x4 row-by-matrix multiplier: keeps its own copy of the
// stored right matrix, predicts each multiply row and compares the output words.
// Depends on m4rm_pkg for the element, row and matrix types.
`timescale 1ns / 1ps

module m4rm_checker
    import m4rm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic       func,
    input  wire logic [1:0] row_index,
    input  wire elem_t      elem_0,
    input  wire elem_t      elem_1,
    input  wire elem_t      elem_2,
    input  wire elem_t      elem_3,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire elem_t      prod_0,
    input  wire elem_t      prod_1,
    input  wire elem_t      prod_2,
    input  wire elem_t      prod_3,
    input  wire logic       saturated,
    output int              fail_count,
    output int              rows_pending
);

    typedef struct packed {
        row_t cols;
        logic clip;
    } product_row_t;

    mat_t         right_rows;
    product_row_t expected_rows[$];
    product_row_t want;
    row_t         got;

    // Each term is a full 64-bit product shifted down arithmetically; only the
    // total of the four terms is clipped to the element range.
    function automatic product_row_t mul_row(input row_t a);
        product_row_t res;
        longint       acc;
        longint       term;
        res.clip = 1'b0;
        for (int j = 0; j < DIM; j++)
        begin
            acc = 0;
            for (int k = 0; k < DIM; k++)
            begin
                term = longint'($signed(a[k])) * longint'($signed(right_rows[k][j]));
                acc += term >>> FRAC_BITS;
            end
            if (acc > longint'(ELEM_MAX))
            begin
                acc      = longint'(ELEM_MAX);
                res.clip = 1'b1;
            end
            else if (acc < longint'(ELEM_MIN))
            begin
                acc      = longint'(ELEM_MIN);
                res.clip = 1'b1;
            end
            res.cols[j] = elem_t'(acc);
        end
        return res;
    endfunction

    task automatic report_error(input string msg);
        if (fail_count < 50)
            $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_rows = '0;
            expected_rows.delete();
            fail_count   = 0;
            rows_pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {prod_3, prod_2, prod_1, prod_0};
                if (expected_rows.size() == 0)
                    report_error($sformatf("result word %h with no multiply outstanding", got));
                else
                begin
                    want = expected_rows.pop_front();
                    for (int j = 0; j < DIM; j++)
                        if (got[j] !== want.cols[j])
                            report_error($sformatf("prod_%0d is %h, expected %h",
                                                   j, got[j], want.cols[j]));
                    if (saturated !== want.clip)
                        report_error($sformatf("saturated is %b, expected %b",
                                               saturated, want.clip));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (func == FUNC_LOAD)
                    right_rows[row_index] = {elem_3, elem_2, elem_1, elem_0};
                else
                    expected_rows.push_back(mul_row({elem_3, elem_2, elem_1, elem_0}));
            end
            rows_pending = expected_rows.size();
        end
    end

endmodule

>>> verif/tb_matrix4x4_row_multiply_top.sv
// Testbench top for the 4x4 row-by-matrix multiplier: drives load and multiply
// words with random gaps and output stalls, and gives the verdict.
// Depends on m4rm_pkg, matrix4x4_row_multiply_top and m4rm_checker.
`timescale 1ns / 1ps

module tb_matrix4x4_row_multiply_top;

    import m4rm_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       func;
    logic [1:0] row_index;
    elem_t      elem_0;
    elem_t      elem_1;
    elem_t      elem_2;
    elem_t      elem_3;
    logic       out_valid;
    logic       out_stall;
    elem_t      prod_0;
    elem_t      prod_1;
    elem_t      prod_2;
    elem_t      prod_3;
    logic       saturated;
    int         fail_count;
    int         rows_pending;

    matrix4x4_row_multiply_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .row_index (row_index),
        .elem_0    (elem_0),
        .elem_1    (elem_1),
        .elem_2    (elem_2),
        .elem_3    (elem_3),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .prod_0    (prod_0),
        .prod_1    (prod_1),
        .prod_2    (prod_2),
        .prod_3    (prod_3),
        .saturated (saturated)
    );

    m4rm_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .row_index    (row_index),
        .elem_0       (elem_0),
        .elem_1       (elem_1),
        .elem_2       (elem_2),
        .elem_3       (elem_3),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .prod_0       (prod_0),
        .prod_1       (prod_1),
        .prod_2       (prod_2),
        .prod_3       (prod_3),
        .saturated    (saturated),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Mostly back-to-back, sometimes a short gap, now and then a long pause.
    function automatic int gap_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 9))
            0:       return ELEM_MAX;
            1:       return ELEM_MIN;
            2, 3, 4: return elem_t'($urandom_range(0, 32'h000F_FFFF)) - elem_t'(32'h0008_0000);
            5:       return elem_t'($urandom_range(0, 3)) - elem_t'(2);
            default: return elem_t'($urandom());
        endcase
    endfunction

    function automatic row_t rand_row();
        row_t r;
        for (int k = 0; k < DIM; k++)
            r[k] = rand_elem();
        return r;
    endfunction

    function automatic row_t fill_row(input elem_t v);
        row_t r;
        for (int k = 0; k < DIM; k++)
            r[k] = v;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic f, input logic [1:0] idx, input row_t r, input int gap);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func      = f;
        row_index = idx;
        {elem_3, elem_2, elem_1, elem_0} = r;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
            repeat (n) @(negedge clk);
            n = gap_len(1'b0);
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    initial
    begin
        row_t ident;
        logic f;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FUNC_LOAD;
        row_index = 2'd0;
        elem_0    = '0;
        elem_1    = '0;
        elem_2    = '0;
        elem_3    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The store is all zero after reset, so even extreme rows give zero.
        send_word(FUNC_MUL, 2'd0, fill_row(ELEM_MAX), 0);
        send_word(FUNC_MUL, 2'd2, fill_row(ELEM_MIN), 0);

        // Identity matrix: rows pass through unchanged, row_index is ignored.
        for (int k = 0; k < DIM; k++)
        begin
            ident    = '0;
            ident[k] = elem_t'(32'h0001_0000);
            send_word(FUNC_LOAD, 2'(k), ident, 0);
        end
        send_word(FUNC_MUL, 2'd3, {elem_t'(1), elem_t'(-1), ELEM_MIN, ELEM_MAX}, 0);

        // The smallest step in row 1; a multiply right after the load must see it,
        // and a negative term rounds toward minus infinity.
        send_word(FUNC_LOAD, 2'd1, fill_row(elem_t'(1)), 0);
        send_word(FUNC_MUL, 2'd1, {elem_t'(0), elem_t'(0), elem_t'(-1), elem_t'(0)}, 0);
        send_word(FUNC_MUL, 2'd0, {elem_t'(0), elem_t'(0), elem_t'(3), elem_t'(-5)}, 0);

        // All-extreme matrix: clipping at both ends, and large terms that cancel.
        for (int k = 0; k < DIM; k++)
            send_word(FUNC_LOAD, 2'(k), fill_row(ELEM_MAX), 0);
        send_word(FUNC_MUL, 2'd0, fill_row(ELEM_MAX), 0);
        send_word(FUNC_MUL, 2'd0, fill_row(ELEM_MIN), 0);
        send_word(FUNC_MUL, 2'd0, {ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX}, 0);
        send_word(FUNC_LOAD, 2'd2, fill_row(ELEM_MIN), 0);
        send_word(FUNC_MUL, 2'd1, {ELEM_MAX, ELEM_MIN, ELEM_MIN, ELEM_MAX}, 0);
        send_word(FUNC_MUL, 2'd1, {ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN}, 2);

        // Random mix of loads and multiplies; every fourth stretch runs without gaps.
        for (int i = 0; i < 1900; i++)
        begin
            f = ($urandom_range(0, 9) < 3) ? FUNC_LOAD : FUNC_MUL;
            send_word(f, 2'($urandom_range(0, 3)), rand_row(), gap_len((i / 150) % 4 == 3));
        end
        in_valid = 1'b0;

        while (rows_pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
